>>> hw/rtl/sle_pkg.sv
// Shared constants, codes and types of the spin lattice energy engine.
package sle_pkg;

  // Lattice geometry: the store holds one row of z spins per (x, y) pair.
  localparam int MAX_EXTENT = 16;
  localparam int CW         = $clog2(MAX_EXTENT);
  localparam int RW         = 2 * CW;
  localparam int ROWS       = MAX_EXTENT * MAX_EXTENT;

  // Port widths of the item, result and register fields.
  localparam int OPW    = 3;
  localparam int SITE_W = 4;
  localparam int EXTW   = 5;
  localparam int COUPW  = 16;
  localparam int EW     = 30;
  localparam int CFG_IW = 3;

  // Bond tallies: one row compare yields pop(mask) - 2 * pop(differ).
  localparam int POPW  = $clog2(MAX_EXTENT + 1);
  localparam int BONDW = POPW + 2;
  // Signed agree-minus-disagree count per axis over the whole lattice.
  localparam int CNTW  = $clog2(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT) + 1;
  localparam int PRODW = COUPW + CNTW;

  // Register reset values.
  localparam logic [EXTW-1:0]         EXT_RESET  = EXTW'(MAX_EXTENT);
  localparam logic signed [COUPW-1:0] COUP_RESET = 16'sd256;

  // Opcodes.
  localparam logic [OPW-1:0] OP_WRITE = 3'd0;
  localparam logic [OPW-1:0] OP_FLIP  = 3'd1;
  localparam logic [OPW-1:0] OP_SITE  = 3'd2;
  localparam logic [OPW-1:0] OP_TOTAL = 3'd3;
  localparam logic [OPW-1:0] OP_FILL  = 3'd4;

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_EXT_X  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_EXT_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_EXT_Z  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COUP_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COUP_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_COUP_Z = 3'd5;

  // Write request into the row store.
  typedef struct packed {
    logic                  en;
    logic [RW-1:0]         addr;
    logic [MAX_EXTENT-1:0] data;
  } sle_wr_t;

endpackage

>>> hw/rtl/sle_row_store.sv
// Spin store: one row of z spins per (x, y) address, registered read.
module sle_row_store import sle_pkg::*; (
  input  logic                  clk,
  input  sle_wr_t               wr,
  input  logic [RW-1:0]         rd_addr,
  output logic [MAX_EXTENT-1:0] rd_data
);

  logic [MAX_EXTENT-1:0] mem [ROWS];

  // One write port and one read port per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/sle_bond_count.sv
// Row bond tally: agreeing minus disagreeing spin pairs under a mask.
module sle_bond_count import sle_pkg::*; (
  input  logic [MAX_EXTENT-1:0]   row_a,
  input  logic [MAX_EXTENT-1:0]   row_b,
  input  logic [MAX_EXTENT-1:0]   mask,
  output logic signed [BONDW-1:0] tally
);

  logic [POPW-1:0]  pop_m;
  logic [POPW-1:0]  pop_d;
  logic [BONDW-1:0] diff_u;

  // Count the bonds in play and the ones whose spins differ.
  always_comb begin
    pop_m = '0;
    pop_d = '0;
    for (int k = 0; k < MAX_EXTENT; k++) begin
      pop_m = pop_m + POPW'(mask[k]);
      pop_d = pop_d + POPW'(mask[k] & (row_a[k] ^ row_b[k]));
    end
  end

  // Each agreeing bond counts +1, each differing bond -1.
  assign diff_u = {2'b00, pop_m} - {1'b0, pop_d, 1'b0};
  assign tally  = $signed(diff_u);

endmodule

>>> hw/rtl/spin_lattice_energy_engine.sv
// Top level of the spin lattice energy engine: sequencer, registers and energy MAC.
//
// An item is taken when start is high and busy is low; its one result appears on the
// out_ ports for a single cycle with out_valid high and cannot be stalled. The spin store
// is 256 rows of 16 spins with one read and one write port, and that port sets the timing:
// a bad site or an unused opcode answers in the cycle after the request; write and flip
// do a read-modify-write of one row; a site energy reads 5 rows and then runs one shared
// 16x13 multiplier over the three axes; a total energy reads 3 rows per (x, y) pair in
// use; fill writes every row. Register writes are always ready.
module spin_lattice_energy_engine import sle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPW-1:0]          in_opcode,
  input  logic [SITE_W-1:0]       in_site_x,
  input  logic [SITE_W-1:0]       in_site_y,
  input  logic [SITE_W-1:0]       in_site_z,
  input  logic                    in_spin_up,
  output logic                    out_valid,
  output logic signed [EW-1:0]    out_energy,
  output logic                    out_site_spin,
  output logic                    out_bad_site,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [COUPW-1:0]        cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;

  // What a returning row read is used for.
  localparam logic [1:0] K_NONE   = 2'd0;
  localparam logic [1:0] K_CENTER = 2'd1;
  localparam logic [1:0] K_XN     = 2'd2;
  localparam logic [1:0] K_YN     = 2'd3;

  // Read phases within one row group, and the MAC steps.
  localparam logic [2:0] PH_CENTER     = 3'd0;
  localparam logic [2:0] PH_LAST_SITE  = 3'd4;
  localparam logic [2:0] PH_LAST_TOTAL = 3'd2;
  localparam logic [1:0] MUL_LAST      = 2'd3;

  // Configuration registers.
  logic [EXTW-1:0]         ext_x_r, ext_y_r, ext_z_r;
  logic signed [COUPW-1:0] coup_x_r, coup_y_r, coup_z_r;

  // Sequencer and datapath registers.
  logic [2:0]              state_r;
  logic [OPW-1:0]          op_r;
  logic [CW-1:0]           i_r, j_r, z_r;
  logic                    up_r;
  logic [2:0]              phase_r;
  logic [MAX_EXTENT-1:0]   center_r;
  logic                    rd_vld_r;
  logic [1:0]              rd_kind_r;
  logic signed [CNTW-1:0]  dx_r, dy_r, dz_r;
  logic [1:0]              mul_ph_r;
  logic signed [PRODW-1:0] prod_r;
  logic signed [EW-1:0]    acc_r;
  logic [RW-1:0]           fill_r;
  logic                    out_valid_r;
  logic signed [EW-1:0]    out_energy_r;
  logic                    out_site_spin_r;
  logic                    out_bad_site_r;

  // Combinational helpers.
  logic [EXTW-1:0]         ex, ey, ez;
  logic [MAX_EXTENT-1:0]   ext_mask, zpair_mask, z_onehot;
  logic                    site_mode;
  logic [CW-1:0]           i_inc, i_dec, j_inc, j_dec;
  logic [EXTW-1:0]         i_next, j_next;
  logic                    x_has_next, y_has_next;
  logic [RW-1:0]           rd_addr;
  logic [1:0]              kind_sel;
  logic [2:0]              ph_last;
  logic                    in_site_op, in_bad;
  logic [MAX_EXTENT-1:0]   bond_a, bond_b, bond_m;
  logic signed [BONDW-1:0] bond_tally;
  logic signed [COUPW-1:0] coup_sel;
  logic signed [CNTW-1:0]  cnt_sel;
  logic signed [PRODW-1:0] mul_res;
  logic signed [EW-1:0]    acc_sum;
  logic                    new_bit;
  logic [MAX_EXTENT-1:0]   new_row;
  logic [MAX_EXTENT-1:0]   rd_data;
  sle_wr_t                 wr_req;

  // An extent of zero acts as one, and one above the lattice as the full lattice.
  function automatic logic [EXTW-1:0] eff_ext(input logic [EXTW-1:0] e);
    logic [EXTW-1:0] r;
    r = (e == '0) ? EXTW'(1) : ((e > EXTW'(MAX_EXTENT)) ? EXTW'(MAX_EXTENT) : e);
    return r;
  endfunction

  assign ex = eff_ext(ext_x_r);
  assign ey = eff_ext(ext_y_r);
  assign ez = eff_ext(ext_z_r);

  // Register writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r  <= EXT_RESET;
      ext_y_r  <= EXT_RESET;
      ext_z_r  <= EXT_RESET;
      coup_x_r <= COUP_RESET;
      coup_y_r <= COUP_RESET;
      coup_z_r <= COUP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXT_X:  ext_x_r  <= cfg_wdata[EXTW-1:0];
        REG_EXT_Y:  ext_y_r  <= cfg_wdata[EXTW-1:0];
        REG_EXT_Z:  ext_z_r  <= cfg_wdata[EXTW-1:0];
        REG_COUP_X: coup_x_r <= $signed(cfg_wdata);
        REG_COUP_Y: coup_y_r <= $signed(cfg_wdata);
        REG_COUP_Z: coup_z_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Masks over the z positions of one row.
  always_comb begin
    for (int k = 0; k < MAX_EXTENT; k++) begin
      ext_mask[k] = (EXTW'(k) < ez);
    end
  end

  assign zpair_mask = ext_mask >> 1;
  assign z_onehot   = MAX_EXTENT'(1) << z_r;
  assign site_mode  = (op_r != OP_TOTAL);

  // Neighbor rows of the current (i, j) pair.
  assign i_inc      = i_r + CW'(1);
  assign i_dec      = i_r - CW'(1);
  assign j_inc      = j_r + CW'(1);
  assign j_dec      = j_r - CW'(1);
  assign i_next     = EXTW'(i_r) + EXTW'(1);
  assign j_next     = EXTW'(j_r) + EXTW'(1);
  assign x_has_next = (i_next < ex);
  assign y_has_next = (j_next < ey);

  // Row address and use of the read issued in this phase.
  always_comb begin
    rd_addr  = {i_r, j_r};
    kind_sel = K_NONE;
    case (phase_r)
      3'd0: begin
        kind_sel = K_CENTER;
      end
      3'd1: begin
        rd_addr  = {i_inc, j_r};
        kind_sel = x_has_next ? K_XN : K_NONE;
      end
      3'd2: begin
        if (site_mode) begin
          rd_addr  = {i_dec, j_r};
          kind_sel = (i_r != '0) ? K_XN : K_NONE;
        end else begin
          rd_addr  = {i_r, j_inc};
          kind_sel = y_has_next ? K_YN : K_NONE;
        end
      end
      3'd3: begin
        rd_addr  = {i_r, j_inc};
        kind_sel = y_has_next ? K_YN : K_NONE;
      end
      3'd4: begin
        rd_addr  = {i_r, j_dec};
        kind_sel = (j_r != '0) ? K_YN : K_NONE;
      end
      default: ;
    endcase
  end

  // Last read phase of a row group for each operation.
  always_comb begin
    case (op_r)
      OP_SITE:  ph_last = PH_LAST_SITE;
      OP_TOTAL: ph_last = PH_LAST_TOTAL;
      default:  ph_last = PH_CENTER;
    endcase
  end

  // Address check of an incoming request.
  assign in_site_op = (in_opcode == OP_WRITE) || (in_opcode == OP_FLIP) ||
                      (in_opcode == OP_SITE);
  assign in_bad     = (EXTW'(in_site_x) >= ex) || (EXTW'(in_site_y) >= ey) ||
                      (EXTW'(in_site_z) >= ez);

  // Bond tally operands: z bonds inside the center row, x and y bonds against it.
  always_comb begin
    if (rd_kind_r == K_CENTER) begin
      bond_a = rd_data;
      bond_b = rd_data >> 1;
      bond_m = site_mode ? ((z_onehot & zpair_mask) | (z_onehot >> 1)) : zpair_mask;
    end else begin
      bond_a = center_r;
      bond_b = rd_data;
      bond_m = site_mode ? z_onehot : ext_mask;
    end
  end

  sle_bond_count u_bond (
    .row_a (bond_a),
    .row_b (bond_b),
    .mask  (bond_m),
    .tally (bond_tally)
  );

  // Shared multiplier: one axis coupling times its bond count per step.
  always_comb begin
    case (mul_ph_r)
      2'd0: begin
        coup_sel = coup_x_r;
        cnt_sel  = dx_r;
      end
      2'd1: begin
        coup_sel = coup_y_r;
        cnt_sel  = dy_r;
      end
      2'd2: begin
        coup_sel = coup_z_r;
        cnt_sel  = dz_r;
      end
      default: begin
        coup_sel = '0;
        cnt_sel  = '0;
      end
    endcase
  end

  assign mul_res = coup_sel * cnt_sel;
  // The largest total stays inside the energy limits, so no saturation is needed.
  assign acc_sum = acc_r + EW'(prod_r);

  // Store writes: one modified row, or every row during fill.
  assign new_bit = (op_r == OP_WRITE) ? up_r : ~center_r[z_r];

  always_comb begin
    new_row        = center_r;
    new_row[z_r]   = new_bit;
    wr_req.en      = (state_r == ST_WRITE) || (state_r == ST_FILL);
    wr_req.addr    = (state_r == ST_FILL) ? fill_r : {i_r, j_r};
    wr_req.data    = (state_r == ST_FILL) ? {MAX_EXTENT{up_r}} : new_row;
  end

  sle_row_store u_store (
    .clk     (clk),
    .wr      (wr_req),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, tally accumulation and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;

      // Fold each returning row into the axis counts.
      if (rd_vld_r) begin
        case (rd_kind_r)
          K_CENTER: begin
            center_r <= rd_data;
            dz_r     <= dz_r + CNTW'(bond_tally);
          end
          K_XN:    dx_r <= dx_r + CNTW'(bond_tally);
          K_YN:    dy_r <= dy_r + CNTW'(bond_tally);
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r     <= in_opcode;
            i_r      <= CW'(in_site_x);
            j_r      <= CW'(in_site_y);
            z_r      <= CW'(in_site_z);
            up_r     <= in_spin_up;
            phase_r  <= PH_CENTER;
            dx_r     <= '0;
            dy_r     <= '0;
            dz_r     <= '0;
            acc_r    <= '0;
            mul_ph_r <= '0;
            fill_r   <= '0;
            if (in_site_op && in_bad) begin
              out_valid_r     <= 1'b1;
              out_energy_r    <= '0;
              out_site_spin_r <= 1'b0;
              out_bad_site_r  <= 1'b1;
            end else begin
              case (in_opcode)
                OP_WRITE, OP_FLIP, OP_SITE: state_r <= ST_SCAN;
                OP_TOTAL: begin
                  i_r     <= '0;
                  j_r     <= '0;
                  state_r <= ST_SCAN;
                end
                OP_FILL: state_r <= ST_FILL;
                default: begin
                  out_valid_r     <= 1'b1;
                  out_energy_r    <= '0;
                  out_site_spin_r <= 1'b0;
                  out_bad_site_r  <= 1'b0;
                end
              endcase
            end
          end
        end

        // Issue one row read per cycle; walk (i, j) for the total sweep.
        ST_SCAN: begin
          rd_vld_r  <= 1'b1;
          rd_kind_r <= kind_sel;
          if (phase_r == ph_last) begin
            phase_r <= PH_CENTER;
            if (site_mode) begin
              state_r <= ST_FLUSH;
            end else if (j_next == ey) begin
              j_r <= '0;
              if (i_next == ex) begin
                state_r <= ST_FLUSH;
              end else begin
                i_r <= i_inc;
              end
            end else begin
              j_r <= j_inc;
            end
          end else begin
            phase_r <= phase_r + 3'd1;
          end
        end

        // The last read lands here.
        ST_FLUSH: begin
          state_r <= ((op_r == OP_WRITE) || (op_r == OP_FLIP)) ? ST_WRITE : ST_MUL;
        end

        // Multiply one axis per cycle, add the previous product.
        ST_MUL: begin
          prod_r   <= mul_res;
          mul_ph_r <= mul_ph_r + 2'd1;
          if (mul_ph_r != 2'd0) begin
            acc_r <= acc_sum;
          end
          if (mul_ph_r == MUL_LAST) begin
            out_valid_r     <= 1'b1;
            out_energy_r    <= acc_sum;
            out_site_spin_r <= site_mode ? center_r[z_r] : 1'b0;
            out_bad_site_r  <= 1'b0;
            state_r         <= ST_IDLE;
          end
        end

        ST_WRITE: begin
          out_valid_r     <= 1'b1;
          out_energy_r    <= '0;
          out_site_spin_r <= new_bit;
          out_bad_site_r  <= 1'b0;
          state_r         <= ST_IDLE;
        end

        ST_FILL: begin
          fill_r <= fill_r + RW'(1);
          if (fill_r == '1) begin
            out_valid_r     <= 1'b1;
            out_energy_r    <= '0;
            out_site_spin_r <= up_r;
            out_bad_site_r  <= 1'b0;
            state_r         <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_energy    = out_energy_r;
  assign out_site_spin = out_site_spin_r;
  assign out_bad_site  = out_bad_site_r;

`ifndef SYNTHESIS
  // A result only appears once the sequencer is back in idle.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A site request outside the extents answers at once with the error flag.
  a_bad_site: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_site_op && in_bad) |=> (out_valid && out_bad_site))
    else $error("bad site request not flagged");

  // Returning row data always belongs to a read issued by the scan.
  a_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == ST_SCAN))
    else $error("row data without a scan read");

  // The last MAC step always delivers a result.
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mul_ph_r == MUL_LAST) |=> out_valid)
    else $error("energy sum not delivered");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the spin lattice energy engine: directed and random requests checked against a lattice copy.
module tb_top;
  import sle_pkg::*;

  // Opcodes and register indexes that the block leaves unused.
  localparam logic [OPW-1:0]    OP_SPARE_5  = 3'd5;
  localparam logic [OPW-1:0]    OP_SPARE_6  = 3'd6;
  localparam logic [OPW-1:0]    OP_SPARE_7  = 3'd7;
  localparam logic [CFG_IW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPARE_7 = 3'd7;

  localparam int     SITES      = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
  localparam longint ENERGY_CAP = 64'sd402653184;

  // One answer of the block, as the out_ ports carry it.
  typedef struct packed {
    logic signed [EW-1:0] energy;
    logic                 site_spin;
    logic                 bad_site;
  } lattice_answer_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  logic [OPW-1:0]       in_opcode  = '0;
  logic [SITE_W-1:0]    in_site_x  = '0;
  logic [SITE_W-1:0]    in_site_y  = '0;
  logic [SITE_W-1:0]    in_site_z  = '0;
  logic                 in_spin_up = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IW-1:0]    cfg_index  = '0;
  logic [COUPW-1:0]     cfg_wdata  = '0;
  logic                 busy;
  logic                 out_valid;
  logic signed [EW-1:0] out_energy;
  logic                 out_site_spin;
  logic                 out_bad_site;
  logic                 cfg_ready;

  // Lattice copy kept by the testbench: spins and the register file.
  bit               spin_copy [SITES];
  logic [COUPW-1:0] reg_copy  [6];

  lattice_answer_t  pending_answers [$];
  int               error_count = 0;
  int               burst_left  = 1;
  bit               no_gaps     = 1'b0;

  spin_lattice_energy_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_site_x    (in_site_x),
    .in_site_y    (in_site_y),
    .in_site_z    (in_site_z),
    .in_spin_up   (in_spin_up),
    .out_valid    (out_valid),
    .out_energy   (out_energy),
    .out_site_spin(out_site_spin),
    .out_bad_site (out_bad_site),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Extents of 0 behave as 1 and extents past the lattice size behave as the full size.
  function automatic int eff_ext(logic [EXTW-1:0] e);
    if (e == '0) return 1;
    if (int'(e) > MAX_EXTENT) return MAX_EXTENT;
    return int'(e);
  endfunction

  function automatic int site_at(int x, int y, int z);
    return (x * MAX_EXTENT + y) * MAX_EXTENT + z;
  endfunction

  // A bond is worth +coupling when the two spins agree and -coupling otherwise.
  function automatic longint bond_worth(logic [CFG_IW-1:0] coup_reg, bit a, bit b);
    longint c;
    c = longint'(signed'(reg_copy[coup_reg]));
    return (a == b) ? c : -c;
  endfunction

  function automatic void lattice_reset();
    foreach (spin_copy[i]) spin_copy[i] = 1'b0;
    reg_copy[REG_EXT_X]  = COUPW'(MAX_EXTENT);
    reg_copy[REG_EXT_Y]  = COUPW'(MAX_EXTENT);
    reg_copy[REG_EXT_Z]  = COUPW'(MAX_EXTENT);
    reg_copy[REG_COUP_X] = 16'sd256;
    reg_copy[REG_COUP_Y] = 16'sd256;
    reg_copy[REG_COUP_Z] = 16'sd256;
  endfunction

  // Extent registers keep only their low bits; writes to spare indexes are dropped.
  function automatic void lattice_set_reg(logic [CFG_IW-1:0] idx, logic [COUPW-1:0] data);
    case (idx)
      REG_EXT_X, REG_EXT_Y, REG_EXT_Z: reg_copy[idx] = COUPW'(data[EXTW-1:0]);
      REG_COUP_X, REG_COUP_Y, REG_COUP_Z: reg_copy[idx] = data;
      default: ;
    endcase
  endfunction

  // Applies one request to the lattice copy and returns the answer it must produce.
  function automatic lattice_answer_t lattice_apply(logic [OPW-1:0] op, logic [SITE_W-1:0] sx,
                                                    logic [SITE_W-1:0] sy, logic [SITE_W-1:0] sz,
                                                    logic up);
    lattice_answer_t ans;
    int              ex, ey, ez, x, y, z, c, i, j, k;
    longint          sum;
    bit              s;
    ans = '0;
    sum = 0;
    ex  = eff_ext(reg_copy[REG_EXT_X][EXTW-1:0]);
    ey  = eff_ext(reg_copy[REG_EXT_Y][EXTW-1:0]);
    ez  = eff_ext(reg_copy[REG_EXT_Z][EXTW-1:0]);
    x   = int'(sx);
    y   = int'(sy);
    z   = int'(sz);
    if (op == OP_WRITE || op == OP_FLIP || op == OP_SITE) begin
      // A site outside the extents in use changes nothing and only raises the flag.
      if (x >= ex || y >= ey || z >= ez) begin
        ans.bad_site = 1'b1;
        return ans;
      end
      c = site_at(x, y, z);
      if (op == OP_WRITE) begin
        spin_copy[c] = up;
      end else if (op == OP_FLIP) begin
        spin_copy[c] = ~spin_copy[c];
      end else begin
        s = spin_copy[c];
        if (x + 1 < ex) sum += bond_worth(REG_COUP_X, s, spin_copy[site_at(x + 1, y, z)]);
        if (x > 0)      sum += bond_worth(REG_COUP_X, s, spin_copy[site_at(x - 1, y, z)]);
        if (y + 1 < ey) sum += bond_worth(REG_COUP_Y, s, spin_copy[site_at(x, y + 1, z)]);
        if (y > 0)      sum += bond_worth(REG_COUP_Y, s, spin_copy[site_at(x, y - 1, z)]);
        if (z + 1 < ez) sum += bond_worth(REG_COUP_Z, s, spin_copy[site_at(x, y, z + 1)]);
        if (z > 0)      sum += bond_worth(REG_COUP_Z, s, spin_copy[site_at(x, y, z - 1)]);
      end
      ans.site_spin = spin_copy[c];
    end else if (op == OP_TOTAL) begin
      // Every forward bond inside the extents in use counts once.
      for (i = 0; i < ex; i++) begin
        for (j = 0; j < ey; j++) begin
          for (k = 0; k < ez; k++) begin
            s = spin_copy[site_at(i, j, k)];
            if (i + 1 < ex) sum += bond_worth(REG_COUP_X, s, spin_copy[site_at(i + 1, j, k)]);
            if (j + 1 < ey) sum += bond_worth(REG_COUP_Y, s, spin_copy[site_at(i, j + 1, k)]);
            if (k + 1 < ez) sum += bond_worth(REG_COUP_Z, s, spin_copy[site_at(i, j, k + 1)]);
          end
        end
      end
    end else if (op == OP_FILL) begin
      // Fill reaches every site, in use or not.
      foreach (spin_copy[n]) spin_copy[n] = up;
      ans.site_spin = up;
    end
    if (sum > ENERGY_CAP) sum = ENERGY_CAP;
    if (sum < -ENERGY_CAP) sum = -ENERGY_CAP;
    ans.energy = EW'(sum);
    return ans;
  endfunction

  // Sends one request and records its answer once the block takes it.
  // Called just after a rising edge; start stays high so a following request can go out at once.
  task automatic send_item(logic [OPW-1:0] op, logic [SITE_W-1:0] sx, logic [SITE_W-1:0] sy,
                           logic [SITE_W-1:0] sz, logic up);
    start      <= 1'b1;
    in_opcode  <= op;
    in_site_x  <= sx;
    in_site_y  <= sy;
    in_site_z  <= sz;
    in_spin_up <= up;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(lattice_apply(op, sx, sy, sz, up));
    // The sender goes quiet for a while at the end of each burst.
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Waits until every answer has arrived and the block is idle.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0 || busy) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [COUPW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lattice_set_reg(idx, data);
  endtask

  // Rewrites all six registers while the block is idle; extents carry random upper bits.
  task automatic set_lattice(logic [EXTW-1:0] ex, logic [EXTW-1:0] ey, logic [EXTW-1:0] ez,
                             logic [COUPW-1:0] cx, logic [COUPW-1:0] cy, logic [COUPW-1:0] cz);
    logic [COUPW-1:0] junk;
    drain_results();
    junk = $urandom;
    write_reg(REG_EXT_X, {junk[COUPW-1:EXTW], ex});
    junk = $urandom;
    write_reg(REG_EXT_Y, {junk[COUPW-1:EXTW], ey});
    junk = $urandom;
    write_reg(REG_EXT_Z, {junk[COUPW-1:EXTW], ez});
    write_reg(REG_COUP_X, cx);
    write_reg(REG_COUP_Y, cy);
    write_reg(REG_COUP_Z, cz);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small extents so sweeps stay short, with the odd and the full sizes mixed in.
  function automatic logic [EXTW-1:0] pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return EXTW'($urandom_range(MAX_EXTENT + 1, 31));
    if (r < 22) return EXTW'(MAX_EXTENT);
    if (r < 30) return EXTW'($urandom_range(7, MAX_EXTENT - 1));
    return EXTW'($urandom_range(1, 6));
  endfunction

  function automatic logic [COUPW-1:0] pick_coupling();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    if (r < 25) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return COUPW'($urandom);
  endfunction

  // Coordinates land inside the extent most of the time.
  function automatic logic [SITE_W-1:0] pick_coord(int e);
    if ($urandom_range(0, 9) == 0) return SITE_W'($urandom_range(0, MAX_EXTENT - 1));
    return SITE_W'($urandom_range(0, e - 1));
  endfunction

  task automatic random_item();
    int             ex, ey, ez, r;
    logic [OPW-1:0] op;
    ex = eff_ext(reg_copy[REG_EXT_X][EXTW-1:0]);
    ey = eff_ext(reg_copy[REG_EXT_Y][EXTW-1:0]);
    ez = eff_ext(reg_copy[REG_EXT_Z][EXTW-1:0]);
    r  = $urandom_range(0, 99);
    if (r < 30) op = OP_WRITE;
    else if (r < 50) op = OP_FLIP;
    else if (r < 82) op = OP_SITE;
    else if (r < 90) op = OP_TOTAL;
    else if (r < 96) op = OP_FILL;
    else begin
      case ($urandom_range(0, 2))
        0: op = OP_SPARE_5;
        1: op = OP_SPARE_6;
        default: op = OP_SPARE_7;
      endcase
    end
    send_item(op, pick_coord(ex), pick_coord(ey), pick_coord(ez), 1'($urandom_range(0, 1)));
  endtask

  // Reset values: an unused opcode, a write, then a fill that defines every site before anything is read.
  task automatic test_reset_defaults();
    no_gaps = 1'b1;
    send_item(OP_SPARE_7, 4'hF, 4'hF, 4'hF, 1'b1);
    send_item(OP_WRITE, 4'h0, 4'h0, 4'h0, 1'b1);
    send_item(OP_FILL, 4'h9, 4'h6, 4'h3, 1'b0);
    send_item(OP_SITE, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_TOTAL, 4'h5, 4'hA, 4'h5, 1'b1);
  endtask

  // Far corner and interior sites, flips, two of the unused opcodes and a total sweep.
  task automatic test_corner_sites();
    no_gaps = 1'b0;
    send_item(OP_WRITE, 4'hF, 4'hF, 4'hF, 1'b1);
    send_item(OP_SITE, 4'hF, 4'hF, 4'hF, 1'b0);
    send_item(OP_FLIP, 4'hF, 4'hF, 4'hF, 1'b1);
    send_item(OP_WRITE, 4'h7, 4'h8, 4'h9, 1'b1);
    send_item(OP_SITE, 4'h7, 4'h8, 4'h9, 1'b1);
    send_item(OP_FLIP, 4'h7, 4'h8, 4'h8, 1'b0);
    send_item(OP_SITE, 4'h7, 4'h8, 4'h9, 1'b0);
    send_item(OP_SPARE_5, 4'h1, 4'h2, 4'h3, 1'b1);
    send_item(OP_SPARE_6, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_TOTAL, 4'h0, 4'h0, 4'h0, 1'b0);
  endtask

  // Zero and oversized extents, bad sites on each axis, extreme couplings, spare registers.
  task automatic test_extent_limits();
    set_lattice(5'd0, 5'd0, 5'd0, 16'h8000, 16'h7FFF, 16'h0000);
    send_item(OP_SITE, 4'h0, 4'h0, 4'h0, 1'b0);
    send_item(OP_WRITE, 4'h1, 4'h0, 4'h0, 1'b1);
    send_item(OP_FLIP, 4'h0, 4'h1, 4'h0, 1'b0);
    send_item(OP_SITE, 4'h0, 4'h0, 4'h1, 1'b0);
    send_item(OP_TOTAL, 4'hF, 4'hF, 4'hF, 1'b1);
    set_lattice(5'd31, 5'd17, 5'd16, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_FILL, 4'h0, 4'h0, 4'h0, 1'b1);
    send_item(OP_TOTAL, 4'h0, 4'h0, 4'h0, 1'b0);
    // Writes to the spare indexes must leave every register alone.
    drain_results();
    write_reg(REG_SPARE_6, COUPW'($urandom));
    write_reg(REG_SPARE_7, COUPW'($urandom));
    cfg_valid <= 1'b0;
    send_item(OP_SITE, 4'h8, 4'h8, 4'h8, 1'b1);
    set_lattice(5'd16, 5'd16, 5'd16, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(OP_TOTAL, 4'h3, 4'hC, 4'h3, 1'b0);
  endtask

  // Phases of random requests, each under a fresh register setting.
  task automatic test_random_phases();
    for (int p = 0; p < 24; p++) begin
      set_lattice(pick_extent(), pick_extent(), pick_extent(),
                  pick_coupling(), pick_coupling(), pick_coupling());
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 80; n++) random_item();
    end
  endtask

  // Every answer is compared with the oldest one still pending.
  always @(posedge clk) begin
    lattice_answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("%0t: answer with none pending: energy %0d spin %0b bad %0b",
                 $time, out_energy, out_site_spin, out_bad_site);
      end else begin
        want = pending_answers.pop_front();
        if (out_energy !== want.energy) begin
          error_count++;
          $display("%0t: energy expected %0d actual %0d",
                   $time, $signed(want.energy), out_energy);
        end
        if (out_site_spin !== want.site_spin) begin
          error_count++;
          $display("%0t: site_spin expected %0b actual %0b",
                   $time, want.site_spin, out_site_spin);
        end
        if (out_bad_site !== want.bad_site) begin
          error_count++;
          $display("%0t: bad_site expected %0b actual %0b",
                   $time, want.bad_site, out_bad_site);
        end
      end
    end
  end

  initial begin
    lattice_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_corner_sites();
    test_extent_limits();
    test_random_phases();
    drain_results();
    // Room for any stray answer to show up.
    repeat (40) @(posedge clk);
    if (pending_answers.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("spin_lattice_energy_engine test passed");
    end else begin
      $display("spin_lattice_energy_engine test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("spin_lattice_energy_engine test failed");
    $finish;
  end

endmodule

>>> spin_lattice_energy_engine.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_row_store.sv
hw/rtl/sle_bond_count.sv
hw/rtl/spin_lattice_energy_engine.sv
sim/tb_top.sv
